/* hdl/atm_pkg.sv */
// ----------------------------------------------------------------------------
// atm_pkg - shared types and helpers for the at-mention scanner
// Result record, push bundle, default parameters, byte classes and the
// keyword tables used to tell here/channel/everyone mentions apart.
// ----------------------------------------------------------------------------
package atm_pkg;

  // Default parameter values
  localparam int NAME_MAX_DEF    = 64;
  localparam int OFFSET_BITS_DEF = 16;

  // Fixed field widths
  localparam int START_W = 16;
  localparam int LEN_W   = 7;
  localparam int KIND_W  = 2;
  localparam int TOTAL_W = 16;
  localparam int LIMIT_W = 16;

  // Result queue depth (power of two)
  localparam int FIFO_DEPTH = 4;

  // Run length saturates here
  localparam logic [LEN_W-1:0] RUN_SAT = 7'd127;

  // Mention kinds
  localparam logic [KIND_W-1:0] KIND_USER     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HERE     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHANNEL  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EVERYONE = 2'd3;

  // Keyword prefix flag bits
  localparam int FLAG_HERE     = 0;
  localparam int FLAG_CHANNEL  = 1;
  localparam int FLAG_EVERYONE = 2;

  // Byte codes
  localparam logic [7:0] CHAR_AT  = 8'h40;
  localparam logic [7:0] CHAR_DOT = 8'h2e;
  localparam logic [7:0] CHAR_UND = 8'h5f;
  localparam logic [7:0] CHAR_HYP = 8'h2d;

  // Keywords, left aligned in 64 bits, with their lengths
  localparam logic [63:0] KW_HERE     = {"here", 32'h0};
  localparam logic [63:0] KW_CHANNEL  = {"channel", 8'h0};
  localparam logic [63:0] KW_EVERYONE = "everyone";
  localparam logic [3:0]  KW_HERE_LEN     = 4'd4;
  localparam logic [3:0]  KW_CHANNEL_LEN  = 4'd7;
  localparam logic [3:0]  KW_EVERYONE_LEN = 4'd8;

  typedef struct packed {
    logic               is_summary;
    logic [START_W-1:0] mention_start;
    logic [LEN_W-1:0]   mention_length;
    logic [KIND_W-1:0]  mention_kind;
    logic [TOTAL_W-1:0] mention_total;
    logic               last_of_run;
  } atm_result_t;

  // Up to two results produced by one byte, in order
  typedef struct packed {
    logic [1:0]  count;
    atm_result_t first;
    atm_result_t second;
  } atm_push_t;

  function automatic logic is_name_byte(input logic [7:0] c);
    return (c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39]}) ||
           (c inside {CHAR_DOT, CHAR_UND, CHAR_HYP});
  endfunction

  function automatic logic is_trim_byte(input logic [7:0] c);
    return c inside {CHAR_DOT, CHAR_UND, CHAR_HYP};
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {[8'h41:8'h5a]}) ? c + 8'd32 : c;
  endfunction

  // True when byte c at name position pos breaks the keyword prefix
  function automatic logic kw_miss(input logic [63:0] word, input logic [3:0] word_len,
                                   input logic [LEN_W-1:0] pos, input logic [7:0] c);
    logic [2:0] idx;
    logic [7:0] want;
    idx  = pos[2:0];
    want = word[8*(7-int'(idx)) +: 8];
    return ({3'b000, word_len} > pos) && (to_lower(c) != want);
  endfunction

endpackage

/* hdl/atm_scanner.sv */
// ----------------------------------------------------------------------------
// atm_scanner - per-body mention tracking
// Holds the report limit and the per-body state, and on each accepted byte
// produces the zero, one or two results that byte causes.
// ----------------------------------------------------------------------------
module atm_scanner #(
  parameter int NAME_MAX    = atm_pkg::NAME_MAX_DEF,
  parameter int OFFSET_BITS = atm_pkg::OFFSET_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [atm_pkg::LIMIT_W-1:0] cfg_data,
  input  logic                      acc,
  input  logic [7:0]                text_byte,
  input  logic                      end_of_body,
  output atm_pkg::atm_push_t        push
);
  import atm_pkg::*;

  logic [LIMIT_W-1:0]     report_limit;
  logic                   prev_was_name;
  logic                   in_mention;
  logic [START_W-1:0]     start_offset;
  logic [LEN_W-1:0]       run_length;
  logic [LEN_W-1:0]       trimmed_length;
  logic [2:0]             keyword_prefix_flags;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [TOTAL_W-1:0]     found_count;

  logic                   nb;
  logic                   cont;
  logic                   start_new;
  logic                   finish;
  logic [LEN_W-1:0]       run_length_next;
  logic [LEN_W-1:0]       trimmed_length_next;
  logic [2:0]             keyword_prefix_flags_next;
  logic [LEN_W-1:0]       fin_len;
  logic [2:0]             fin_flags;
  logic                   kept;
  logic                   report;
  logic [TOTAL_W-1:0]     found_count_next;
  logic [KIND_W-1:0]      kind;
  atm_result_t            rep_res;
  atm_result_t            sum_res;

  // Classify the byte and extend the current name run
  always_comb begin
    nb        = is_name_byte(text_byte);
    cont      = in_mention && nb;
    start_new = !cont && (text_byte == CHAR_AT) && !prev_was_name;

    keyword_prefix_flags_next = keyword_prefix_flags;
    if (kw_miss(KW_HERE, KW_HERE_LEN, run_length, text_byte)) begin
      keyword_prefix_flags_next[FLAG_HERE] = 1'b0;
    end
    if (kw_miss(KW_CHANNEL, KW_CHANNEL_LEN, run_length, text_byte)) begin
      keyword_prefix_flags_next[FLAG_CHANNEL] = 1'b0;
    end
    if (kw_miss(KW_EVERYONE, KW_EVERYONE_LEN, run_length, text_byte)) begin
      keyword_prefix_flags_next[FLAG_EVERYONE] = 1'b0;
    end
    run_length_next     = (run_length < RUN_SAT) ? run_length + 1'b1 : run_length;
    trimmed_length_next = is_trim_byte(text_byte) ? trimmed_length : run_length_next;
  end

  // Close a mention: on a byte that ends the run, or on the final byte mid-run
  always_comb begin
    finish    = (in_mention && !cont) || (cont && end_of_body);
    fin_len   = cont ? trimmed_length_next : trimmed_length;
    fin_flags = cont ? keyword_prefix_flags_next : keyword_prefix_flags;
    kept      = finish && (fin_len != '0) && (fin_len < LEN_W'(NAME_MAX));
    report    = kept && (found_count < report_limit);
    found_count_next = (kept && !(&found_count)) ? found_count + 1'b1 : found_count;

    if (fin_flags[FLAG_HERE] && fin_len == LEN_W'(KW_HERE_LEN)) begin
      kind = KIND_HERE;
    end else if (fin_flags[FLAG_CHANNEL] && fin_len == LEN_W'(KW_CHANNEL_LEN)) begin
      kind = KIND_CHANNEL;
    end else if (fin_flags[FLAG_EVERYONE] && fin_len == LEN_W'(KW_EVERYONE_LEN)) begin
      kind = KIND_EVERYONE;
    end else begin
      kind = KIND_USER;
    end
  end

  // Assemble the results in order: mention report first, summary last
  always_comb begin
    rep_res                = '0;
    rep_res.mention_start  = start_offset;
    rep_res.mention_length = fin_len + 1'b1;
    rep_res.mention_kind   = kind;
    rep_res.last_of_run    = !end_of_body;

    sum_res               = '0;
    sum_res.is_summary    = 1'b1;
    sum_res.mention_total = found_count_next;
    sum_res.last_of_run   = 1'b1;

    push = '0;
    if (acc) begin
      if (report && end_of_body) begin
        push.count  = 2'd2;
        push.first  = rep_res;
        push.second = sum_res;
      end else if (report) begin
        push.count = 2'd1;
        push.first = rep_res;
      end else if (end_of_body) begin
        push.count = 2'd1;
        push.first = sum_res;
      end
    end
  end

  // Hold the limit and advance per-body state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      report_limit         <= '1;
      prev_was_name        <= 1'b0;
      in_mention           <= 1'b0;
      start_offset         <= '0;
      run_length           <= '0;
      trimmed_length       <= '0;
      keyword_prefix_flags <= '1;
      byte_position        <= '0;
      found_count          <= '0;
    end else begin
      if (cfg_we) begin
        report_limit <= cfg_data;
      end
      if (acc) begin
        if (end_of_body) begin
          prev_was_name        <= 1'b0;
          in_mention           <= 1'b0;
          start_offset         <= '0;
          run_length           <= '0;
          trimmed_length       <= '0;
          keyword_prefix_flags <= '1;
          byte_position        <= '0;
          found_count          <= '0;
        end else begin
          prev_was_name <= nb;
          found_count   <= found_count_next;
          if (!(&byte_position)) begin
            byte_position <= byte_position + 1'b1;
          end
          if (cont) begin
            run_length           <= run_length_next;
            trimmed_length       <= trimmed_length_next;
            keyword_prefix_flags <= keyword_prefix_flags_next;
          end else if (start_new) begin
            in_mention           <= 1'b1;
            start_offset         <= START_W'(byte_position);
            run_length           <= '0;
            trimmed_length       <= '0;
            keyword_prefix_flags <= '1;
          end else begin
            in_mention <= 1'b0;
          end
        end
      end
    end
  end

`ifndef SYNTH
  a_body_clears: assert property (@(posedge clk) disable iff (rst)
    acc && end_of_body |=> byte_position == '0 && found_count == '0 && !in_mention)
    else $error("per-body state not cleared after final byte");

  a_two_only_at_end: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> end_of_body && !push.first.is_summary && push.second.is_summary)
    else $error("two results outside a final byte");

  a_no_push_idle: assert property (@(posedge clk) disable iff (rst)
    !acc |-> push.count == 2'd0)
    else $error("result pushed without a transfer");

  a_summary_on_end: assert property (@(posedge clk) disable iff (rst)
    acc && end_of_body |-> push.count != 2'd0)
    else $error("final byte gave no summary");
`endif

endmodule

/* hdl/atm_result_fifo.sv */
// ----------------------------------------------------------------------------
// atm_result_fifo - result queue
// Takes up to two results per cycle and hands them out one per transfer.
// Asks the scanner side to stall while fewer than two slots are free.
// ----------------------------------------------------------------------------
module atm_result_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  atm_pkg::atm_push_t   push,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output atm_pkg::atm_result_t out_res
);
  import atm_pkg::*;

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

  atm_result_t         slots [FIFO_DEPTH];
  logic [PTR_W-1:0]    wptr;
  logic [PTR_W-1:0]    rptr;
  logic [FILL_W-1:0]   fill;
  logic [FILL_W-1:0]   fill_next;
  logic [PTR_W-1:0]    wptr_second;
  logic                pop;

  assign pop         = out_valid && !out_stall;
  assign out_valid   = fill != '0;
  assign out_res     = slots[rptr];
  assign full        = fill > FILL_W'(FIFO_DEPTH - 2);
  assign wptr_second = wptr + 1'b1;
  assign fill_next   = fill + FILL_W'(push.count) - FILL_W'(pop);

  // Write pushed results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wptr_second] <= push.second;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      wptr <= wptr + PTR_W'(push.count);
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      fill <= fill_next;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> !full)
    else $error("push while queue is full");

  a_held_stays: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && push.count == 2'd0 |=> out_valid && $stable(out_res))
    else $error("stalled result changed");
`endif

endmodule

/* hdl/at_mention_scanner.sv */
// ----------------------------------------------------------------------------
// at_mention_scanner - streaming @mention finder
// Scans a message body byte by byte and reports mentions plus a summary.
// ----------------------------------------------------------------------------
// Takes one body byte per cycle while in_stall is low. Each byte produces
// zero or one mention report, and the final byte adds a summary with the
// kept-mention count, so a byte yields at most two results. Results leave
// one per cycle while out_stall is low, through a four-entry queue; in_stall
// rises whenever fewer than two queue slots are free, which a final byte's
// two results can cause even with out_stall low. report_limit may be
// written at any cycle while the block is idle; cfg_ready is always high.
module at_mention_scanner #(
  parameter int NAME_MAX    = atm_pkg::NAME_MAX_DEF,
  parameter int OFFSET_BITS = atm_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [atm_pkg::LIMIT_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   text_byte,
  input  logic                         end_of_body,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         is_summary,
  output logic [atm_pkg::START_W-1:0]  mention_start,
  output logic [atm_pkg::LEN_W-1:0]    mention_length,
  output logic [atm_pkg::KIND_W-1:0]   mention_kind,
  output logic [atm_pkg::TOTAL_W-1:0]  mention_total,
  output logic                         last_of_run
);
  import atm_pkg::*;

  atm_push_t   push;
  atm_result_t out_res;
  logic        acc;

  assign cfg_ready = 1'b1;
  assign acc       = in_valid && !in_stall;

  atm_scanner #(
    .NAME_MAX    (NAME_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scanner (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .acc         (acc),
    .text_byte   (text_byte),
    .end_of_body (end_of_body),
    .push        (push)
  );

  atm_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Spread the queued result onto the output fields
  assign is_summary     = out_res.is_summary;
  assign mention_start  = out_res.mention_start;
  assign mention_length = out_res.mention_length;
  assign mention_kind   = out_res.mention_kind;
  assign mention_total  = out_res.mention_total;
  assign last_of_run    = out_res.last_of_run;

endmodule

/* dv/tb_at_mention_scanner.sv */
// ----------------------------------------------------------------------------
// tb_at_mention_scanner - self-checking bench for the @mention scanner
// Streams message bodies into the scanner, first from a short table of hand
// picked cases and then as random bodies built from mentions, words and
// noise. A built-in predictor tracks the scan state and queues the expected
// mention reports and summaries; every result transfer is checked against
// the oldest entry. Sender idles in bursts, receiver stalls on its own
// pattern, and the report limit is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_at_mention_scanner;
  import atm_pkg::*;

  localparam int KEEP_CAP = -1;          // table rows that leave report_limit alone
  localparam int HOLD_CYCLES = 400;      // long receiver hold-off
  localparam int RAND_ITEMS = 1950;
  localparam int RAND_PHASES = 5;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  typedef struct {
    int          cap;
    string       txt;
    int          raw;
    int          reps;
    bit          eob;
    int          n_exp;
    atm_result_t e0;
    atm_result_t e1;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          text_byte = '0;
  logic                end_of_body = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                is_summary;
  logic [START_W-1:0]  mention_start;
  logic [LEN_W-1:0]    mention_length;
  logic [KIND_W-1:0]   mention_kind;
  logic [TOTAL_W-1:0]  mention_total;
  logic                last_of_run;

  at_mention_scanner uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .text_byte      (text_byte),
    .end_of_body    (end_of_body),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .is_summary     (is_summary),
    .mention_start  (mention_start),
    .mention_length (mention_length),
    .mention_kind   (mention_kind),
    .mention_total  (mention_total),
    .last_of_run    (last_of_run)
  );

  always #5 clk = ~clk;

  // Scan state mirrored by the predictor
  logic [LIMIT_W-1:0]  report_cap;
  bit                  prev_name;
  bit                  in_name;
  logic [START_W-1:0]  at_pos;
  logic [LEN_W-1:0]    run_len;
  logic [LEN_W-1:0]    kept_len;
  logic [2:0]          kw_hits;
  logic [START_W-1:0]  byte_pos;
  logic [TOTAL_W-1:0]  found;

  string kw_word [3] = '{"here", "channel", "everyone"};  // indexed by FLAG_*
  string name_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._-";
  string sep_pool = " ,;!?:\n(";

  atm_result_t expect_q [$];   // results still owed by the scanner
  atm_result_t pred_q [$];     // results of the sequence being predicted
  logic [7:0]  body_q [$];     // bytes of the sequence about to be sent
  dir_row_t    dir_rows [$];

  int unsigned errors = 0;
  int unsigned burst_left = 0;
  int unsigned hold_reqs = 0;

  function automatic bit is_trim_char(input logic [7:0] c);
    return c == CHAR_DOT || c == CHAR_UND || c == CHAR_HYP;
  endfunction

  function automatic bit is_name_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || is_trim_char(c);
  endfunction

  function automatic atm_result_t mention_res(input logic [START_W-1:0] start,
                                              input logic [LEN_W-1:0] len,
                                              input logic [KIND_W-1:0] kind,
                                              input bit last);
    atm_result_t r;
    r = '0;
    r.mention_start  = start;
    r.mention_length = len;
    r.mention_kind   = kind;
    r.last_of_run    = last;
    return r;
  endfunction

  function automatic atm_result_t summary_res(input logic [TOTAL_W-1:0] total);
    atm_result_t r;
    r = '0;
    r.is_summary    = 1'b1;
    r.mention_total = total;
    r.last_of_run   = 1'b1;
    return r;
  endfunction

  task automatic clear_body_state;
    prev_name = 1'b0;
    in_name   = 1'b0;
    at_pos    = '0;
    run_len   = '0;
    kept_len  = '0;
    kw_hits   = '1;
    byte_pos  = '0;
    found     = '0;
  endtask

  // Close the open name: drop empty or overlong names, count the rest,
  // report while under the limit
  task automatic close_name;
    logic [KIND_W-1:0] kind;
    in_name = 1'b0;
    if (kept_len != 0 && kept_len < NAME_MAX_DEF) begin
      if (found < report_cap) begin
        kind = KIND_USER;
        if (kw_hits[FLAG_HERE] && kept_len == kw_word[FLAG_HERE].len())
          kind = KIND_HERE;
        else if (kw_hits[FLAG_CHANNEL] && kept_len == kw_word[FLAG_CHANNEL].len())
          kind = KIND_CHANNEL;
        else if (kw_hits[FLAG_EVERYONE] && kept_len == kw_word[FLAG_EVERYONE].len())
          kind = KIND_EVERYONE;
        pred_q.push_back(mention_res(at_pos, kept_len + 7'd1, kind, 1'b0));
      end
      if (found != '1) found++;
    end
  endtask

  // Advance the predictor by one byte, appending its results to pred_q
  task automatic scan_byte(input logic [7:0] c, input bit last);
    bit          nb;
    logic [7:0]  lc;
    int unsigned first_new;
    nb = is_name_char(c);
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    first_new = pred_q.size();
    if (in_name && nb) begin
      for (int k = 0; k < 3; k++)
        if (run_len < kw_word[k].len() && lc != kw_word[k][run_len]) kw_hits[k] = 1'b0;
      if (run_len != RUN_SAT) run_len++;
      if (!is_trim_char(c)) kept_len = run_len;
    end else begin
      if (in_name) close_name();
      if (c == CHAR_AT && !prev_name) begin
        in_name  = 1'b1;
        at_pos   = byte_pos;
        run_len  = '0;
        kept_len = '0;
        kw_hits  = '1;
      end
    end
    prev_name = nb;
    if (last) begin
      if (in_name) close_name();
      pred_q.push_back(summary_res(found));
      clear_body_state();
    end else if (byte_pos != '1) begin
      byte_pos++;
    end
    if (pred_q.size() > first_new) pred_q[pred_q.size()-1].last_of_run = 1'b1;
  endtask

  // Offer one byte, idling between bursts, and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    text_byte   <= b;
    end_of_body <= last;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Predict body_q as a whole, queue the expectations, then send it
  task automatic run_seq(input bit eob_at_end, input int n_typed,
                         input atm_result_t t0, input atm_result_t t1);
    int n;
    n = body_q.size();
    pred_q.delete();
    for (int i = 0; i < n; i++) scan_byte(body_q[i], eob_at_end && i == n - 1);
    if (n_typed > 0) begin
      pred_q.delete();
      pred_q.push_back(t0);
      if (n_typed > 1) pred_q.push_back(t1);
    end
    foreach (pred_q[i]) expect_q.push_back(pred_q[i]);
    for (int i = 0; i < n; i++) send_byte(body_q[i], eob_at_end && i == n - 1);
  endtask

  // Write report_limit once the scanner has drained
  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    in_valid <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    report_cap = v;
  endtask

  function automatic void add_row(input int cap, input string txt, input int raw,
                                  input int reps, input bit eob, input int n_exp = 0,
                                  input atm_result_t e0 = '0,
                                  input atm_result_t e1 = '0);
    dir_row_t r;
    r.cap   = cap;
    r.txt   = txt;
    r.raw   = raw;
    r.reps  = reps;
    r.eob   = eob;
    r.n_exp = n_exp;
    r.e0    = e0;
    r.e1    = e1;
    dir_rows.push_back(r);
  endfunction

  // Build one random body: half the tokens mentions, the rest words, separators and noise
  task automatic make_body;
    int unsigned tokens, pick, len;
    string       kw;
    logic [7:0]  c;
    body_q.delete();
    tokens = $urandom_range(1, 10);
    repeat (tokens) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        body_q.push_back(CHAR_AT);
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          // keyword, near miss or exact, in mixed case
          kw = kw_word[pick];
          len = kw.len();
          case ($urandom_range(0, 3))
            0: len = len - 1;
            1: len = len + 1;
            default: ;
          endcase
          for (int i = 0; i < len; i++) begin
            c = (i < kw.len()) ? kw[i] : name_pool[$urandom_range(0, 61)];
            if ($urandom_range(0, 1) == 1 && c >= "a" && c <= "z") c = c - 8'd32;
            body_q.push_back(c);
          end
        end else begin
          case (pick)
            7: len = $urandom_range(60, 70);
            8: len = 0;
            default: len = $urandom_range(1, 8);
          endcase
          for (int i = 0; i < len; i++)
            body_q.push_back(pick == 9 ? name_pool[$urandom_range(62, 64)]
                                       : name_pool[$urandom_range(0, 64)]);
        end
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 2)) body_q.push_back(name_pool[$urandom_range(62, 64)]);
      end else if (pick < 14) begin
        body_q.push_back(sep_pool[$urandom_range(0, sep_pool.len() - 1)]);
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 6)) body_q.push_back(name_pool[$urandom_range(0, 64)]);
      end else begin
        body_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver: switch stall patterns now and then; long hold-off on request
  rx_mode_e    rx_mode = RX_FREE;
  int unsigned rx_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    rx_cycle++;
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        RX_FREE:     out_stall <= 1'b0;
        RX_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
        RX_HEAVY:    out_stall <= ($urandom_range(0, 99) < 70);
        RX_PERIODIC: out_stall <= (rx_cycle % 4 == 0);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    atm_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expect_q.size() == 0) begin
        $display("%0t: unexpected result, summary %0d start %0d length %0d total %0d",
                 $time, is_summary, mention_start, mention_length, mention_total);
        errors++;
      end else begin
        want = expect_q.pop_front();
        check_field("is_summary", want.is_summary, is_summary);
        check_field("mention_start", want.mention_start, mention_start);
        check_field("mention_length", want.mention_length, mention_length);
        check_field("mention_kind", want.mention_kind, mention_kind);
        check_field("mention_total", want.mention_total, mention_total);
        check_field("last_of_run", want.last_of_run, last_of_run);
      end
    end
  end

  initial begin : stimulus
    dir_row_t          r;
    int unsigned       sent;
    logic [LIMIT_W-1:0] cap;

    report_cap = '1;
    clear_body_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases: keywords in any case, trimming, non-mentions, raw
    // extremes, name length limits, report limit, offset and count saturation
    add_row(KEEP_CAP, "@here", 0, 1, 1, 2,
            mention_res(0, 5, KIND_HERE, 0), summary_res(1));
    add_row(KEEP_CAP, "@CHANNEL", 0, 1, 1, 2,
            mention_res(0, 8, KIND_CHANNEL, 0), summary_res(1));
    add_row(KEEP_CAP, "@EveryOne", 0, 1, 1, 2,
            mention_res(0, 9, KIND_EVERYONE, 0), summary_res(1));
    add_row(KEEP_CAP, "hi @bob.", 0, 1, 1, 2,
            mention_res(3, 4, KIND_USER, 0), summary_res(1));
    add_row(KEEP_CAP, "a@b", 0, 1, 1, 1, summary_res(0));
    add_row(KEEP_CAP, "@", 0, 1, 1, 1, summary_res(0));
    add_row(KEEP_CAP, "", 8'h00, 1, 0);
    add_row(KEEP_CAP, "", 8'hFF, 1, 0);
    add_row(KEEP_CAP, "@Here- @chan,@everyone_ @@al x@y @HERE", 0, 1, 1);
    add_row(KEEP_CAP, "@", 0, 1, 0);
    add_row(KEEP_CAP, "n", 0, 63, 0);
    add_row(KEEP_CAP, " @", 0, 1, 0);
    add_row(KEEP_CAP, "q", 0, 64, 0);
    add_row(KEEP_CAP, " @", 0, 1, 0);
    add_row(KEEP_CAP, "z", 0, 200, 0);
    add_row(KEEP_CAP, "! @", 0, 1, 0);
    add_row(KEEP_CAP, "k", 0, 63, 0);
    add_row(KEEP_CAP, "._- @x", 0, 1, 1);
    add_row(0, "@a @b", 0, 1, 1, 1, summary_res(2));
    add_row(1, "@a @b @c", 0, 1, 1, 2,
            mention_res(0, 2, KIND_USER, 1), summary_res(3));
    add_row(16'hFFFF, " ", 0, 65540, 0);
    add_row(KEEP_CAP, "@ab", 0, 1, 1, 2,
            mention_res(16'hFFFF, 3, KIND_USER, 0), summary_res(1));
    add_row(2, "@a ", 0, 65537, 0);
    add_row(KEEP_CAP, "@zz", 0, 1, 1);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.cap != KEEP_CAP) write_limit(LIMIT_W'(r.cap));
      body_q.delete();
      repeat (r.reps) begin
        if (r.txt.len() == 0) body_q.push_back(8'(r.raw));
        else for (int j = 0; j < r.txt.len(); j++) body_q.push_back(r.txt[j]);
      end
      run_seq(r.eob, r.n_exp, r.e0, r.e1);
    end

    // Random bodies in phases, each with its own report limit
    sent = 0;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       cap = LIMIT_W'($urandom_range(3, 65535));
        1:       cap = '0;
        2:       cap = LIMIT_W'(1);
        3:       cap = '1;
        default: cap = LIMIT_W'($urandom_range(2, 4));
      endcase
      write_limit(cap);
      // hold the receiver off while the sender keeps pushing
      if (ph == 3) hold_reqs <= hold_reqs + 1;
      while (sent < (ph + 1) * RAND_ITEMS / RAND_PHASES) begin
        make_body();
        run_seq(1'b1, 0, '0, '0);
        sent += body_q.size();
      end
    end

    // Drain, then let any stray result show up
    in_valid <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0 && expect_q.size() == 0)
      $display("PASS at_mention_scanner");
    else
      $display("FAIL at_mention_scanner");
    $finish;
  end

  initial begin : watchdog
    #30000000;
    $display("FAIL at_mention_scanner");
    $finish;
  end

endmodule

/* files.f */
hdl/atm_pkg.sv
hdl/atm_scanner.sv
hdl/atm_result_fifo.sv
hdl/at_mention_scanner.sv
dv/tb_at_mention_scanner.sv
